FILE: rtl/core/atcp_pkg.sv
package atcp_pkg;

    // Field widths of one word on each channel.
    localparam int BYTE_W   = 8;
    localparam int TARGET_W = 4;
    localparam int VALUE_W  = 31;

    // Width of the signed hundredths value before the position scaling.
    localparam int HUND_W   = 24;
    localparam int DIGIT_W  = 10;

    // Capacity of the key and field stores.
    localparam int KEY_CAP      = 3;
    localparam int FIELD_CAP    = 7;
    localparam int FLEN_W       = 4;
    localparam int FIELD_IDX_W  = 3;
    localparam int KEY_IDX_W    = 2;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [TARGET_W-1:0] t_target;

    // Register address on the configuration port.
    localparam logic [1:0] REG_MOTOR_SELECT = 2'd0;

    // Command characters.
    localparam t_byte CH_EQ    = 8'h3D;
    localparam t_byte CH_END   = 8'h21;
    localparam t_byte CH_MINUS = 8'h2D;
    localparam t_byte CH_P     = 8'h50;
    localparam t_byte CH_I     = 8'h49;
    localparam t_byte CH_D     = 8'h44;
    localparam t_byte CH_S     = 8'h53;
    localparam t_byte CH_LO_O  = 8'h6F;
    localparam t_byte CH_LO_P  = 8'h70;
    localparam t_byte CH_LO_E  = 8'h65;
    localparam t_byte CH_LO_S  = 8'h73;
    localparam t_byte CH_1     = 8'h31;
    localparam t_byte CH_2     = 8'h32;

    localparam logic signed [DIGIT_W-1:0] DIGIT0 = 10'sd48;
    localparam logic signed [VALUE_W-1:0] POS_MUL = 31'sd360;

    // Register write targets.
    localparam t_target TGT_NONE    = 4'd0;
    localparam t_target TGT_POS_KP  = 4'd1;
    localparam t_target TGT_POS_KI  = 4'd2;
    localparam t_target TGT_POS_KD  = 4'd3;
    localparam t_target TGT_SPD_KP  = 4'd4;
    localparam t_target TGT_SPD_KI  = 4'd5;
    localparam t_target TGT_SPD_KD  = 4'd6;
    localparam t_target TGT_SPEED   = 4'd7;
    localparam t_target TGT_POSITION = 4'd8;

    // Only this motor number enables writes.
    localparam t_byte MOTOR_ACTIVE = 8'd1;
    localparam t_byte MOTOR_RESET  = 8'd1;

    // Field lengths that carry a value.
    localparam logic [FLEN_W-1:0] LEN_D_DD   = 4'd4;
    localparam logic [FLEN_W-1:0] LEN_DD_DD  = 4'd5;
    localparam logic [FLEN_W-1:0] LEN_DDD_DD = 4'd6;
    localparam logic [FLEN_W-1:0] FLEN_MAX   = 4'd15;

endpackage

FILE: rtl/core/ascii_tuning_command_parser.sv
// ASCII tuning command parser.
// Input channel: one received byte per word on i_rx_byte, handshaked by
// i_in_valid and o_in_ready. A command such as "P1=1.25!" is stored byte by
// byte and the '!' byte ends it.
// Output channel: one word per '!' byte on o_target and o_value, handshaked
// by o_out_valid and i_out_ready. Target 0 means no register is written.
// Any other byte produces no output word.
// Configuration: an APB-style port holds motor_select at address 0; only the
// value 1 enables writes.
// Throughput is one byte per cycle while o_in_ready is high. An accepted '!'
// byte loads the decode stage with the key and the hundredths value; the
// word then moves into the output register, which applies the position
// scaling.
// When the receiver stalls, the output register and the decode stage hold
// their words and o_in_ready drops only once the decode stage is full and
// cannot move, so up to two results wait inside the block.
// Synchronous reset empties both stages, clears the byte position, field
// length and key store and sets motor_select to 1.
module ascii_tuning_command_parser
    import atcp_pkg::*;
#(
    parameter int MAX_LEN = 200
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [BYTE_W-1:0]         i_rx_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [TARGET_W-1:0]       o_target,
    output logic signed [VALUE_W-1:0] o_value,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [1:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);
    localparam logic [POS_W-1:0] POS_KEY_END = POS_W'(KEY_CAP);
    localparam logic [FLEN_W-1:0] FLEN_CAP = FLEN_W'(FIELD_CAP);

    t_byte                     r_motor;
    logic [POS_W-1:0]          r_pos;
    t_byte                     r_key [KEY_CAP];
    t_byte                     r_field [FIELD_CAP];
    logic [FLEN_W-1:0]         r_flen;

    logic                      r_s1_valid;
    t_target                   r_s1_target;
    logic signed [HUND_W-1:0]  r_s1_hund;
    logic                      r_out_valid;
    t_target                   r_out_target;
    logic signed [VALUE_W-1:0] r_out_value;

    logic                      in_fire;
    logic                      is_end;
    logic                      store_en;
    logic                      out_free;
    logic                      s1_free;

    t_target                   n_s1_target;
    logic signed [HUND_W-1:0]  n_s1_hund;
    logic signed [VALUE_W-1:0] n_out_value;
    logic signed [VALUE_W-1:0] hund_ext;

    logic                      neg;
    logic [FLEN_W-1:0]         len_eff;
    t_byte                     fb [FIELD_CAP-1];
    logic signed [HUND_W-1:0]  dg [FIELD_CAP-1];
    logic signed [HUND_W-1:0]  mag;

    // ------------------------------------------------------------------
    // Handshakes.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_in_ready = s1_free;
    assign in_fire    = i_in_valid && s1_free;
    assign is_end     = (i_rx_byte == CH_END);
    assign store_en   = in_fire && !is_end && (r_pos < POS_LIMIT);

    assign o_out_valid = r_out_valid;
    assign o_target    = r_out_target;
    assign o_value     = r_out_value;

    // ------------------------------------------------------------------
    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr == REG_MOTOR_SELECT) ? {24'd0, r_motor} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor <= MOTOR_RESET;
        end else if (psel && penable && pwrite && pready) begin
            r_motor <= pwdata[BYTE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Command store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_flen <= '0;
            for (int k = 0; k < KEY_CAP; k++) begin
                r_key[k] <= '0;
            end
        end else if (in_fire && is_end) begin
            r_pos  <= '0;
            r_flen <= '0;
            for (int k = 0; k < KEY_CAP; k++) begin
                r_key[k] <= '0;
            end
        end else if (store_en) begin
            r_pos <= r_pos + 1'b1;
            if (r_pos < POS_KEY_END) begin
                r_key[r_pos[KEY_IDX_W-1:0]] <= i_rx_byte;
            end
            if (i_rx_byte == CH_EQ) begin
                r_flen <= '0;
            end else if (r_flen < FLEN_MAX) begin
                r_flen <= r_flen + 1'b1;
            end
        end
    end

    // The field bytes are payload; only entries written since the last '='
    // of the current command are ever read.
    always_ff @(posedge i_clk) begin
        if (store_en && (i_rx_byte != CH_EQ) && (r_flen < FLEN_CAP)) begin
            r_field[r_flen[FIELD_IDX_W-1:0]] <= i_rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Key decode.
    always_comb begin
        n_s1_target = TGT_NONE;
        if (r_motor == MOTOR_ACTIVE) begin
            if (r_key[0] == CH_P && r_key[1] == CH_1) begin
                n_s1_target = TGT_POS_KP;
            end else if (r_key[0] == CH_I && r_key[1] == CH_1) begin
                n_s1_target = TGT_POS_KI;
            end else if (r_key[0] == CH_D && r_key[1] == CH_1) begin
                n_s1_target = TGT_POS_KD;
            end else if (r_key[0] == CH_P && r_key[1] == CH_2) begin
                n_s1_target = TGT_SPD_KP;
            end else if (r_key[0] == CH_I && r_key[1] == CH_2) begin
                n_s1_target = TGT_SPD_KI;
            end else if (r_key[0] == CH_D && r_key[1] == CH_2) begin
                n_s1_target = TGT_SPD_KD;
            end else if (r_key[0] == CH_S && r_key[1] == CH_LO_P
                         && r_key[2] == CH_LO_E) begin
                n_s1_target = TGT_SPEED;
            end else if (r_key[0] == CH_P && r_key[1] == CH_LO_O
                         && r_key[2] == CH_LO_S) begin
                n_s1_target = TGT_POSITION;
            end
        end
    end

    // ------------------------------------------------------------------
    // Value decode: drop a leading minus, then weight the digits by the
    // field length. The dot position is skipped without looking at it.
    assign neg     = (r_flen != '0) && (r_field[0] == CH_MINUS);
    assign len_eff = r_flen - FLEN_W'(neg);

    always_comb begin
        for (int k = 0; k < FIELD_CAP - 1; k++) begin
            fb[k] = neg ? r_field[k + 1] : r_field[k];
            dg[k] = HUND_W'(signed'({2'b00, fb[k]}) - DIGIT0);
        end
    end

    always_comb begin
        case (len_eff)
            LEN_D_DD: begin
                mag = dg[0] * 24'sd100 + dg[2] * 24'sd10 + dg[3];
            end
            LEN_DD_DD: begin
                mag = dg[0] * 24'sd1000 + dg[1] * 24'sd100
                    + dg[3] * 24'sd10 + dg[4];
            end
            LEN_DDD_DD: begin
                mag = dg[0] * 24'sd10000 + dg[1] * 24'sd1000
                    + dg[2] * 24'sd100 + dg[4] * 24'sd10 + dg[5];
            end
            default: begin
                mag = '0;
            end
        endcase
    end

    always_comb begin
        if (n_s1_target == TGT_NONE) begin
            n_s1_hund = '0;
        end else if (neg) begin
            n_s1_hund = -mag;
        end else begin
            n_s1_hund = mag;
        end
    end

    // ------------------------------------------------------------------
    // Decode stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= in_fire && is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_target <= n_s1_target;
            r_s1_hund   <= n_s1_hund;
        end
    end

    // ------------------------------------------------------------------
    // Output register with position scaling.
    assign hund_ext = VALUE_W'(r_s1_hund);

    always_comb begin
        if (r_s1_target == TGT_POSITION) begin
            n_out_value = hund_ext * POS_MUL;
        end else begin
            n_out_value = hund_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_target <= r_s1_target;
            r_out_value  <= n_out_value;
        end
    end

`ifndef ASSERT_OFF
    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LIMIT)
        else $error("byte position beyond limit");

    a_end_enters_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && is_end |=> r_s1_valid)
        else $error("terminating byte lost before decode stage");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_target == TGT_NONE) |-> (r_out_value == '0))
        else $error("nonzero value without a target");

    a_overlong_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !is_end && (r_pos == POS_LIMIT) |=> $stable(r_pos) && $stable(r_flen))
        else $error("overlong command byte was stored");

    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_target <= TGT_POSITION))
        else $error("target code out of range");
`endif

endmodule
